FILE: hdl/otsu_pkg.sv
// Shared widths, types and the pixel binning function of the Otsu threshold finder.
`default_nettype none
package otsu_pkg;
   localparam int COUNT_WIDTH = 23;
   localparam int SUM_W = COUNT_WIDTH + 8;
   localparam int GAP_W = SUM_W + COUNT_WIDTH;
   localparam int WP_W = 2 * COUNT_WIDTH;
   localparam int G2_W = 2 * GAP_W;
   localparam int CMP_W = G2_W + WP_W;
   localparam int MA_W = G2_W;
   localparam int MB_W = GAP_W;
   localparam int MP_W = MA_W + MB_W;
   localparam int BINS = 256;
   localparam int BIN_W = $clog2(BINS);
   localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(BINS - 1);
   localparam logic [BIN_W-1:0] NO_SPLIT_BIN = BIN_W'(127);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic                 inc;
      logic                 rd;
      logic [BIN_W-1:0]     addr;
      logic                 clear;
   } hist_ctl_type;

   function automatic logic [BIN_W-1:0] pixel_bin(input logic [15:0] raw);
      logic [11:0] b;
      b = 12'((17'(raw[14:0]) + 17'd8) >> 4);
      if (raw[15]) begin
         return '0;
      end else if (b > 12'(BINS - 1)) begin
         return BIN_MAX;
      end else begin
         return b[BIN_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

FILE: hdl/otsu_hist.sv
// Histogram memory with read-increment-write pipeline, forwarding and per-bin valid bits.
`default_nettype none
module otsu_hist
   import otsu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hist_ctl_type           ctl,
   output logic                        busy,
   output logic [COUNT_WIDTH-1:0]      count
);
   logic [COUNT_WIDTH-1:0] ram [BINS];
   logic [BINS-1:0]        valid_ff;
   logic [COUNT_WIDTH-1:0] rdata_ff;
   logic                   rvalid_ff;
   logic                   s1_valid_ff;
   logic [BIN_W-1:0]       s1_bin_ff;
   logic                   lw_valid_ff;
   logic [BIN_W-1:0]       lw_bin_ff;
   logic [COUNT_WIDTH-1:0] lw_cnt_ff;
   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] cnt_in;

   always_comb begin
      if (lw_valid_ff && (lw_bin_ff == s1_bin_ff)) begin
         cur = lw_cnt_ff;
      end else if (rvalid_ff) begin
         cur = rdata_ff;
      end else begin
         cur = '0;
      end
      cnt_in = cur + COUNT_WIDTH'(1);
   end

   assign count = cur;
   assign busy = s1_valid_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= ram[ctl.addr];
      if (s1_valid_ff) begin
         ram[s1_bin_ff] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff <= ctl.addr;
      lw_bin_ff <= s1_bin_ff;
      lw_cnt_ff <= cnt_in;
      if (reset) begin
         valid_ff <= '0;
         rvalid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= '0;
         rvalid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[ctl.addr];
         s1_valid_ff <= ctl.inc;
         lw_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            valid_ff[s1_bin_ff] <= 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

FILE: hdl/otsu_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
`default_nettype none
module otsu_mul
   import otsu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MA_W-1:0]   a,
   input  wire logic [MB_W-1:0]   b,
   output logic                   busy,
   output logic [MP_W-1:0]        product
);
   logic [MP_W-1:0] acc_ff;
   logic [MP_W-1:0] a_ff;
   logic [MB_W-1:0] b_ff;
   logic            busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         acc_ff <= '0;
         a_ff <= MP_W'(a);
         b_ff <= b;
         busy_ff <= (b != '0);
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
         busy_ff <= ((b_ff >> 1) != '0);
      end
   end

   assign busy = busy_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: hdl/otsu_threshold_finder.sv
// Top level: pixel intake, per-frame threshold sweep sequencer and result register.
// Pixels are taken one per cycle while idle; histogram updates are pipelined.
// On the last transaction of a frame it stops taking pixels and sweeps up to 256 bins.
// Each bin that splits the pixels runs up to six products on a bit-serial multiplier,
// four for the first candidate; an empty frame skips the sweep and answers at once.
// Synchronous reset clears the histogram valid bits, counters and handshake state.
`default_nettype none
module otsu_threshold_finder
   import otsu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [15:0]   req_tdata,   // pixel[15:0]
   input  wire logic          req_tuser,   // has_pixel
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // threshold[7:0]
   output logic [1:0]         rsp_tuser    // empty_frame, overflow
);
   typedef enum logic [3:0] {
      S_IDLE, S_DRAIN, S_RD, S_BIN, S_MUL_GO, S_MUL_WAIT, S_TAKE, S_NEXT, S_OUT
   } state_type;
   typedef enum logic [2:0] {OP_X, OP_Y, OP_WP, OP_G2, OP_LHS, OP_RHS} op_type;

   state_type              state_ff;
   op_type                 op_ff;
   logic [COUNT_WIDTH-1:0] total_ff, w_bg_ff, w_fg_ff;
   logic [SUM_W-1:0]       sum_ff, sum_bg_ff;
   logic                   ovf_ff, empty_ff, have_ff;
   logic [BIN_W-1:0]       t_ff, best_bin_ff;
   logic [GAP_W-1:0]       x_ff, gap_ff;
   logic [WP_W-1:0]        wprod_ff, best_wp_ff;
   logic [G2_W-1:0]        g2_ff, best_g2_ff;
   logic [CMP_W-1:0]       lhs_ff;

   hist_ctl_type           hctl;
   logic                   hist_busy;
   logic [COUNT_WIDTH-1:0] hist_cnt;
   logic                   mul_start, mul_busy;
   logic [MA_W-1:0]        mul_a;
   logic [MB_W-1:0]        mul_b;
   logic [MP_W-1:0]        mul_p;
   logic                   req_acc, rsp_acc, take_pix;
   logic [BIN_W-1:0]       bin;
   logic [COUNT_WIDTH-1:0] nw;
   logic [GAP_W-1:0]       y_p;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign rsp_tdata = best_bin_ff;
   assign rsp_tuser = {ovf_ff, empty_ff};
   assign bin = pixel_bin(req_tdata);
   assign take_pix = req_acc && req_tuser && (total_ff != COUNT_MAX);
   assign nw = w_bg_ff + hist_cnt;
   assign y_p = mul_p[GAP_W-1:0];

   always_comb begin
      hctl.inc = take_pix;
      hctl.rd = (state_ff == S_RD);
      hctl.addr = hctl.rd ? t_ff : bin;
      hctl.clear = rsp_acc;
   end

   always_comb begin
      mul_start = (state_ff == S_MUL_GO);
      unique case (op_ff)
         OP_X: begin
            mul_a = MA_W'(sum_bg_ff);
            mul_b = MB_W'(total_ff);
         end
         OP_Y: begin
            mul_a = MA_W'(sum_ff);
            mul_b = MB_W'(w_bg_ff);
         end
         OP_WP: begin
            mul_a = MA_W'(w_bg_ff);
            mul_b = MB_W'(w_fg_ff);
         end
         OP_G2: begin
            mul_a = MA_W'(gap_ff);
            mul_b = MB_W'(gap_ff);
         end
         OP_LHS: begin
            mul_a = g2_ff;
            mul_b = MB_W'(best_wp_ff);
         end
         OP_RHS: begin
            mul_a = best_g2_ff;
            mul_b = MB_W'(wprod_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   otsu_hist u_hist (
      .clock (clock),
      .reset (reset),
      .ctl   (hctl),
      .busy  (hist_busy),
      .count (hist_cnt)
   );

   otsu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_X;
         total_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         empty_ff <= 1'b0;
         have_ff <= 1'b0;
         best_bin_ff <= NO_SPLIT_BIN;
         t_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (req_tuser) begin
                     if (take_pix) begin
                        total_ff <= total_ff + COUNT_WIDTH'(1);
                        sum_ff <= sum_ff + SUM_W'(bin);
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                  end
                  if (req_tlast) begin
                     state_ff <= S_DRAIN;
                  end
               end
            end
            S_DRAIN: begin
               if (!hist_busy) begin
                  best_bin_ff <= NO_SPLIT_BIN;
                  if (total_ff == '0) begin
                     empty_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     empty_ff <= 1'b0;
                     t_ff <= '0;
                     w_bg_ff <= '0;
                     sum_bg_ff <= '0;
                     have_ff <= 1'b0;
                     best_g2_ff <= '0;
                     best_wp_ff <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_BIN;
            end
            S_BIN: begin
               w_bg_ff <= nw;
               w_fg_ff <= total_ff - nw;
               if (nw == '0) begin
                  state_ff <= S_NEXT;
               end else if (total_ff == nw) begin
                  state_ff <= S_OUT;
               end else begin
                  sum_bg_ff <= sum_bg_ff + SUM_W'(SUM_W'(t_ff) * SUM_W'(hist_cnt));
                  op_ff <= OP_X;
                  state_ff <= S_MUL_GO;
               end
            end
            S_MUL_GO: begin
               state_ff <= S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
               if (!mul_busy) begin
                  state_ff <= S_MUL_GO;
                  unique case (op_ff)
                     OP_X: begin
                        x_ff <= mul_p[GAP_W-1:0];
                        op_ff <= OP_Y;
                     end
                     OP_Y: begin
                        gap_ff <= (x_ff >= y_p) ? (x_ff - y_p) : (y_p - x_ff);
                        op_ff <= OP_WP;
                     end
                     OP_WP: begin
                        wprod_ff <= mul_p[WP_W-1:0];
                        op_ff <= OP_G2;
                     end
                     OP_G2: begin
                        g2_ff <= mul_p[G2_W-1:0];
                        op_ff <= OP_LHS;
                        if (!have_ff) begin
                           state_ff <= S_TAKE;
                        end
                     end
                     OP_LHS: begin
                        lhs_ff <= mul_p[CMP_W-1:0];
                        op_ff <= OP_RHS;
                     end
                     OP_RHS: begin
                        state_ff <= (lhs_ff > mul_p[CMP_W-1:0]) ? S_TAKE : S_NEXT;
                     end
                     default: begin
                        state_ff <= S_NEXT;
                     end
                  endcase
               end
            end
            S_TAKE: begin
               best_bin_ff <= t_ff;
               best_g2_ff <= g2_ff;
               best_wp_ff <= wprod_ff;
               have_ff <= 1'b1;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (t_ff == BIN_MAX) begin
                  state_ff <= S_OUT;
               end else begin
                  t_ff <= t_ff + BIN_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_OUT: begin
               if (rsp_acc) begin
                  total_ff <= '0;
                  sum_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Input accepted while a result is pending.");

   a_sweep_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> !hist_busy)
      else $error("Sweep read overlaps a histogram update.");

   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |=> (total_ff == '0) && (sum_ff == '0))
      else $error("Counters not cleared after a result transaction.");

   a_empty_thr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == NO_SPLIT_BIN))
      else $error("Empty frame result without the no-split threshold.");
endmodule
`default_nettype wire

FILE: tb/otsu_threshold_finder_test.sv
// Self-checking testbench of the Otsu threshold finder with a predictor, random frames and idling.
`timescale 1ns / 100ps
`default_nettype none
module otsu_threshold_finder_test;
   import otsu_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int IDLE_PCT = 12;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // pixel[15:0]
   logic        req_tuser;   // has_pixel
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // threshold[7:0]
   logic [1:0]  rsp_tuser;   // empty_frame, overflow

   typedef struct {
      logic [7:0] threshold;
      logic       empty_frame;
      logic       overflow;
   } verdict_type;

   verdict_type pending_verdicts[$];
   longint unsigned bin_count[BINS];
   longint unsigned frame_pixels;
   longint unsigned frame_level_sum;
   bit          frame_overflow;
   bit          quiet;
   bit          failed;
   longint      cycles;

   otsu_threshold_finder uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int level_of(input logic signed [15:0] pix);
      int v;
      if (pix < 0) begin
         return 0;
      end
      v = (int'(pix) + 8) >>> 4;
      return (v > 255) ? 255 : v;
   endfunction

   function automatic logic [7:0] best_split();
      longint unsigned w_lo, w_hi, s_lo;
      logic [159:0] x, y, gap, wprod, best_gap, best_wprod, lhs, rhs;
      logic [7:0] best;
      bit have;
      w_lo = 0;
      s_lo = 0;
      have = 0;
      best = NO_SPLIT_BIN;
      best_gap = '0;
      best_wprod = '0;
      for (int t = 0; t < BINS; t++) begin
         w_lo += bin_count[t];
         if (w_lo == 0) continue;
         w_hi = frame_pixels - w_lo;
         if (w_hi == 0) break;
         s_lo += longint'(t) * bin_count[t];
         x = 160'(s_lo) * 160'(frame_pixels);
         y = 160'(w_lo) * 160'(frame_level_sum);
         gap = (x >= y) ? x - y : y - x;
         wprod = 160'(w_lo) * 160'(w_hi);
         if (have) begin
            lhs = gap * gap * best_wprod;
            rhs = best_gap * best_gap * wprod;
            if (lhs <= rhs) continue;
         end
         have = 1;
         best = 8'(t);
         best_gap = gap;
         best_wprod = wprod;
      end
      return best;
   endfunction

   function automatic void account_item(input logic [15:0] pix, input bit has, input bit fend);
      verdict_type v;
      int lvl;
      if (has) begin
         if (frame_pixels >= longint'(COUNT_MAX)) begin
            frame_overflow = 1;
         end else begin
            lvl = level_of(pix);
            bin_count[lvl]++;
            frame_pixels++;
            frame_level_sum += lvl;
         end
      end
      if (!fend) return;
      v.empty_frame = (frame_pixels == 0);
      v.threshold = v.empty_frame ? NO_SPLIT_BIN : best_split();
      v.overflow = frame_overflow;
      pending_verdicts.push_back(v);
      foreach (bin_count[i]) bin_count[i] = 0;
      frame_pixels = 0;
      frame_level_sum = 0;
      frame_overflow = 0;
   endfunction

   task automatic send_item(input logic [15:0] pix, input bit has, input bit fend);
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= has;
      req_tlast <= fend;
      do @(posedge clock); while (!req_tready);
      account_item(pix, has, fend);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic settle();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_frame(input int n, input int levels, input bit wild);
      logic [15:0] pool[8];
      logic [15:0] pix;
      foreach (pool[i]) pool[i] = 16'($urandom_range(4095));
      for (int i = 0; i < n; i++) begin
         if (wild) pix = 16'($urandom);
         else pix = pool[$urandom_range(levels - 1)] + 16'($urandom_range(15));
         if ($urandom_range(99) < 5) send_item(16'($urandom), 1'b0, 1'b0);
         send_item(pix, 1'b1, i == n - 1);
      end
   endtask

   task automatic test_empty_and_single();
      send_item(16'h0000, 1'b0, 1'b1);
      send_item(16'hFFFF, 1'b0, 1'b1);
      send_item(16'h0640, 1'b1, 1'b1);
      send_item(16'h0100, 1'b1, 1'b0);
      send_item(16'h0100, 1'b1, 1'b0);
      send_item(16'h0100, 1'b0, 1'b1);
   endtask

   task automatic test_extremes();
      send_item(16'h8000, 1'b1, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0);
      send_item(16'h0000, 1'b1, 1'b0);
      send_item(16'h0007, 1'b1, 1'b0);
      send_item(16'h0008, 1'b1, 1'b0);
      send_item(16'h1234, 1'b0, 1'b0);
      send_item(16'h0FF7, 1'b1, 1'b0);
      send_item(16'h0FF8, 1'b1, 1'b0);
      send_item(16'h7FFF, 1'b1, 1'b1);
   endtask

   task automatic test_ties();
      send_item(16'h0100, 1'b1, 1'b0);
      send_item(16'h0200, 1'b1, 1'b0);
      send_item(16'h0300, 1'b1, 1'b0);
      send_item(16'h0400, 1'b1, 1'b1);
   endtask

   task automatic test_random_frames();
      int sent;
      sent = 0;
      while (sent < 500) begin
         int n;
         n = $urandom_range(40, 1);
         send_frame(n, $urandom_range(8, 1), $urandom_range(99) < 15);
         sent += n;
      end
   endtask

   task automatic test_no_idle();
      quiet = 1;
      for (int i = 0; i < 4; i++) send_frame($urandom_range(30, 5), 3, 1'b0);
      quiet = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected transaction: threshold %0d", rsp_tdata);
            failed = 1;
         end else begin
            v = pending_verdicts.pop_front();
            if (rsp_tdata !== v.threshold) begin
               $error("threshold: expected %0d, actual %0d", v.threshold, rsp_tdata);
               failed = 1;
            end
            if (rsp_tuser[0] !== v.empty_frame) begin
               $error("empty_frame: expected %0d, actual %0d", v.empty_frame, rsp_tuser[0]);
               failed = 1;
            end
            if (rsp_tuser[1] !== v.overflow) begin
               $error("overflow: expected %0d, actual %0d", v.overflow, rsp_tuser[1]);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      cycles = 0;
      failed = 0;
      quiet = 0;
      frame_pixels = 0;
      frame_level_sum = 0;
      frame_overflow = 0;
      foreach (bin_count[i]) bin_count[i] = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_single();
      test_extremes();
      test_ties();
      test_random_frames();
      test_no_idle();
      req_tvalid <= 1'b0;
      settle();
      repeat (100) @(posedge clock);
      if (!failed && pending_verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
